FILE: rtl/core/dbc_pkg.sv
// Shared types and constants for the two-button debounce and chord block.
package dbc_pkg;

  localparam int unsigned COUNT_BITS_DEF = 8;
  localparam int unsigned REQ_W          = 8;
  localparam logic [REQ_W-1:0] REQ_COUNT_RST = 8'd10;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_BTN1  = 2'd1,
    EV_BTN2  = 2'd2,
    EV_CHORD = 2'd3
  } event_e;

  typedef struct packed {
    logic clr_pending;
    logic clr_chord;
  } key_clear_t;

  typedef struct packed {
    logic stable;
    logic stable_nxt;
    logic pending;
    logic chord;
  } key_status_t;

endpackage

FILE: rtl/core/dbc_in_if.sv
// Input channel: tick or poll word with raw button levels.
interface dbc_in_if;
  logic valid;
  logic ready;
  logic action;
  logic btn1_raw;
  logic btn2_raw;

  modport source (output valid, output action, output btn1_raw, output btn2_raw,
                  input ready);
  modport sink (input valid, input action, input btn1_raw, input btn2_raw,
                output ready);
endinterface

FILE: rtl/core/dbc_out_if.sv
// Output channel: event code and debounced button states.
interface dbc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       btn1_stable;
  logic       btn2_stable;

  modport source (output valid, output event_res, output btn1_stable,
                  output btn2_stable, input ready);
  modport sink (input valid, input event_res, input btn1_stable, input btn2_stable,
                output ready);
endinterface

FILE: rtl/core/two_button_debounce_chord.sv
// Top level: input register, two debounce units, poll arbitration, result register.
// Path: input register holds a word; its result then moves to the result register.
// Throughput: one word per cycle; the input register advances whenever the
//   result register is empty or being drained.
// Reset (rst_ni, async, active low): counts and flags clear, buttons read released,
//   required count returns to 10, both channels empty.
module two_button_debounce_chord #(
  parameter int unsigned COUNT_BITS = dbc_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  dbc_in_if.sink                    in_i,
  dbc_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [dbc_pkg::REQ_W-1:0] cfg_wdata_i
);
  import dbc_pkg::*;

  logic [REQ_W-1:0] req_q;

  logic s1_valid_q;
  logic s1_action_q, s1_b1_q, s1_b2_q;

  logic out_valid_q;
  event_e event_q, event_d;
  logic stab1_q, stab2_q;

  logic advance, tick_en, poll_en;
  key_clear_t  clr1, clr2;
  key_status_t st1, st2;

  assign advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign tick_en = advance && (s1_action_q == ACT_TICK);
  assign poll_en = advance && (s1_action_q == ACT_POLL);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= REQ_COUNT_RST;
    end else if (cfg_we_i) begin
      req_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_action_q <= in_i.action;
      s1_b1_q     <= in_i.btn1_raw;
      s1_b2_q     <= in_i.btn2_raw;
    end
  end

  // poll priority: chord, then button two, then button one
  always_comb begin
    event_d = EV_NONE;
    clr1    = '0;
    clr2    = '0;
    if (poll_en) begin
      priority if (st1.chord || st2.chord) begin
        event_d        = EV_CHORD;
        clr1.clr_chord = 1'b1;
        clr2.clr_chord = 1'b1;
      end else if (st2.stable && st2.pending) begin
        event_d          = EV_BTN2;
        clr2.clr_pending = 1'b1;
      end else if (st1.stable && st1.pending) begin
        event_d          = EV_BTN1;
        clr1.clr_pending = 1'b1;
      end else begin
        event_d = EV_NONE;
      end
    end
  end

  dbc_key #(.COUNT_BITS(COUNT_BITS)) u_key1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_en),
    .raw_i       (s1_b1_q),
    .other_raw_i (s1_b2_q),
    .required_i  (req_q),
    .clear_i     (clr1),
    .status_o    (st1)
  );

  dbc_key #(.COUNT_BITS(COUNT_BITS)) u_key2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_en),
    .raw_i       (s1_b2_q),
    .other_raw_i (s1_b1_q),
    .required_i  (req_q),
    .clear_i     (clr2),
    .status_o    (st2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_d;
      stab1_q <= st1.stable_nxt;
      stab2_q <= st2.stable_nxt;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_res   = event_q;
  assign out_o.btn1_stable = stab1_q;
  assign out_o.btn2_stable = stab2_q;

endmodule

FILE: rtl/core/dbc_key.sv
// Per-button debounce state: repeat counter, stable level, pending and chord flags.
module dbc_key #(
  parameter int unsigned COUNT_BITS = dbc_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  logic                        raw_i,
  input  logic                        other_raw_i,
  input  logic [dbc_pkg::REQ_W-1:0]   required_i,
  input  dbc_pkg::key_clear_t         clear_i,
  output dbc_pkg::key_status_t        status_o
);
  import dbc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > REQ_W) ? COUNT_BITS : REQ_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                  stable_q, stable_d;
  logic                  last_q, last_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  pending_q, pending_d;
  logic                  chord_q, chord_d;

  logic [COUNT_BITS-1:0] count_inc;
  logic [CMP_W-1:0]      cnt_x, req_x;
  logic                  hit;

  always_comb begin
    if (raw_i == last_q) begin
      count_inc = (count_q == CNT_MAX) ? count_q : count_q + COUNT_BITS'(1);
    end else begin
      count_inc = '0;
    end
    cnt_x = CMP_W'(count_inc);
    req_x = CMP_W'(required_i);
    hit   = (cnt_x == req_x) && (stable_q != raw_i);
  end

  always_comb begin
    stable_d  = stable_q;
    last_d    = last_q;
    count_d   = count_q;
    pending_d = pending_q;
    chord_d   = chord_q;
    if (tick_i) begin
      last_d  = raw_i;
      count_d = count_inc;
      if (hit) begin
        stable_d  = raw_i;
        count_d   = '0;
        pending_d = raw_i;
        chord_d   = chord_q | (stable_q & ~raw_i & other_raw_i);
      end
    end
    if (clear_i.clr_pending) begin
      pending_d = 1'b0;
    end
    if (clear_i.clr_chord) begin
      chord_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= 1'b0;
      last_q    <= 1'b0;
      count_q   <= '0;
      pending_q <= 1'b0;
      chord_q   <= 1'b0;
    end else begin
      stable_q  <= stable_d;
      last_q    <= last_d;
      count_q   <= count_d;
      pending_q <= pending_d;
      chord_q   <= chord_d;
    end
  end

  assign status_o.stable     = stable_q;
  assign status_o.stable_nxt = stable_d;
  assign status_o.pending    = pending_q;
  assign status_o.chord      = chord_q;

endmodule
